### src/ntt_pkg.sv
// ----------------------------------------------------------------------------
// ntt_pkg
// Shared constants and types for the nearest track table.
// ----------------------------------------------------------------------------
package ntt_pkg;

  localparam int DEPTH   = 16;
  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int ID_W    = 32;
  localparam int RNG_W   = 16;
  localparam int STAT_W  = 3;
  localparam int SLOT_W  = 4;
  localparam int OCNT_W  = 5;

  localparam logic [STAT_W-1:0] ST_LISTED   = 3'd0;
  localparam logic [STAT_W-1:0] ST_APPENDED = 3'd1;
  localparam logic [STAT_W-1:0] ST_REPLACED = 3'd2;
  localparam logic [STAT_W-1:0] ST_DROPPED  = 3'd3;
  localparam logic [STAT_W-1:0] ST_SWEPT    = 3'd4;

  localparam logic ACT_REPORT = 1'b0;
  localparam logic ACT_SWEEP  = 1'b1;

  // running search result handed from cell to cell
  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] hit_idx;
    logic [IDX_W-1:0] max_idx;
    logic [RNG_W-1:0] max_rng;
  } acc_t;

  // write command broadcast to every cell
  typedef struct packed {
    logic             we;
    logic             mark_only;
    logic             clr;
    logic [IDX_W-1:0] idx;
    logic [ID_W-1:0]  id;
    logic [RNG_W-1:0] rng;
    logic             mark;
  } wr_t;

endpackage

### src/ntt_cell.sv
// ----------------------------------------------------------------------------
// ntt_cell
// One table slot plus one stage of the lookup chain.
// ----------------------------------------------------------------------------
module ntt_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [ntt_pkg::IDX_W-1:0] idx,
  input  logic [ntt_pkg::CNT_W-1:0] count,
  input  logic [ntt_pkg::ID_W-1:0]  probe_id,
  input  ntt_pkg::wr_t              wr,
  input  ntt_pkg::acc_t             acc_in,
  output ntt_pkg::acc_t             acc_out,
  output logic [ntt_pkg::ID_W-1:0]  ent_id,
  output logic [ntt_pkg::RNG_W-1:0] ent_rng,
  output logic                      ent_mark
);
  import ntt_pkg::*;

  acc_t acc_next;
  logic in_use;

  assign in_use = CNT_W'(idx) < count;

  always_comb begin
    acc_next = acc_in;
    if (in_use && !acc_in.found) begin
      if (ent_id == probe_id) begin
        acc_next.found   = 1'b1;
        acc_next.hit_idx = idx;
      end else if (idx == '0 || ent_rng > acc_in.max_rng) begin
        // first slot seeds the maximum, strict compare keeps lowest slot on ties
        acc_next.max_rng = ent_rng;
        acc_next.max_idx = idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_out <= acc_next;
  end

  always_ff @(posedge clk) begin
    if (wr.we && wr.idx == idx && !wr.mark_only) begin
      ent_id  <= wr.id;
      ent_rng <= wr.rng;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent_mark <= 1'b0;
    end else if (wr.clr) begin
      ent_mark <= 1'b0;
    end else if (wr.we && wr.idx == idx) begin
      ent_mark <= wr.mark;
    end
  end

endmodule

### src/nearest_track_table.sv
// ----------------------------------------------------------------------------
// nearest_track_table
// Table of up to DEPTH tracks that keeps the nearest ones.
// ----------------------------------------------------------------------------
// A report word is looked up by sending a search record down a row of DEPTH
// cells, one cell per cycle, and the result is loaded into the output
// register once the output is free. An end-of-scan word walks the table one
// step a cycle, each step either keeping a slot or filling it with the last
// entry, and its result is loaded once the walk is done and the output is
// free. One word is worked on at a time; the input opens again in the same
// cycle that the result enters the output register, even while that result
// is still stalled.
module nearest_track_table (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         action,
  input  logic [ntt_pkg::ID_W-1:0]     track_id,
  input  logic [ntt_pkg::RNG_W-1:0]    range_sixteenths_km,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [ntt_pkg::STAT_W-1:0]   status,
  output logic [ntt_pkg::SLOT_W-1:0]   slot,
  output logic [ntt_pkg::OCNT_W-1:0]   entry_count,
  output logic [ntt_pkg::OCNT_W-1:0]   removed_count
);
  import ntt_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_FIN   = 2'd2;
  localparam logic [1:0] S_SWEEP = 2'd3;

  logic [1:0]       state, state_next;
  logic [IDX_W-1:0] step, step_next;
  logic [CNT_W-1:0] count, count_next;
  logic [CNT_W-1:0] k, k_next;
  logic [CNT_W-1:0] removed, removed_next;
  logic [ID_W-1:0]  probe_id;
  logic [RNG_W-1:0] probe_rng;

  acc_t             acc [DEPTH];
  acc_t             acc_init;
  logic [ID_W-1:0]  ent_id   [DEPTH];
  logic [RNG_W-1:0] ent_rng  [DEPTH];
  logic             ent_mark [DEPTH];
  wr_t              wr;

  logic             out_free;
  logic             load;
  logic [STAT_W-1:0] o_status;
  logic [IDX_W-1:0]  o_slot;
  logic [IDX_W-1:0]  k_idx, last_idx;
  acc_t              res;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign acc_init = '0;
  assign res      = acc[DEPTH-1];
  assign k_idx    = k[IDX_W-1:0];
  assign last_idx = IDX_W'(count - CNT_W'(1));

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    ntt_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .idx      (IDX_W'(i)),
      .count    (count),
      .probe_id (probe_id),
      .wr       (wr),
      .acc_in   ((i == 0) ? acc_init : acc[(i == 0) ? 0 : i-1]),
      .acc_out  (acc[i]),
      .ent_id   (ent_id[i]),
      .ent_rng  (ent_rng[i]),
      .ent_mark (ent_mark[i])
    );
  end

  always_comb begin
    state_next   = state;
    step_next    = step;
    count_next   = count;
    k_next       = k;
    removed_next = removed;
    wr           = '0;
    load         = 1'b0;
    o_status     = ST_DROPPED;
    o_slot       = '0;
    unique case (state)
      S_IDLE: begin
        step_next    = '0;
        k_next       = '0;
        removed_next = '0;
        if (in_valid) begin
          state_next = (action == ACT_SWEEP) ? S_SWEEP : S_SCAN;
        end
      end
      S_SCAN: begin
        step_next = step + IDX_W'(1);
        if (step == IDX_W'(DEPTH - 1)) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          load       = 1'b1;
          state_next = S_IDLE;
          wr.mark    = 1'b1;
          wr.id      = probe_id;
          wr.rng     = probe_rng;
          if (res.found) begin
            wr.we        = 1'b1;
            wr.mark_only = 1'b1;
            wr.idx       = res.hit_idx;
            o_status     = ST_LISTED;
            o_slot       = res.hit_idx;
          end else if (count < CNT_W'(DEPTH)) begin
            wr.we      = 1'b1;
            wr.idx     = count[IDX_W-1:0];
            count_next = count + CNT_W'(1);
            o_status   = ST_APPENDED;
            o_slot     = count[IDX_W-1:0];
          end else if (probe_rng < res.max_rng) begin
            wr.we    = 1'b1;
            wr.idx   = res.max_idx;
            o_status = ST_REPLACED;
            o_slot   = res.max_idx;
          end
        end
      end
      S_SWEEP: begin
        if (k < count) begin
          if (!ent_mark[k_idx]) begin
            // fill the hole with the last entry, mark included
            wr.we        = 1'b1;
            wr.idx       = k_idx;
            wr.id        = ent_id[last_idx];
            wr.rng       = ent_rng[last_idx];
            wr.mark      = ent_mark[last_idx];
            count_next   = count - CNT_W'(1);
            removed_next = removed + CNT_W'(1);
          end else begin
            k_next = k + CNT_W'(1);
          end
        end else if (out_free) begin
          wr.clr     = 1'b1;
          load       = 1'b1;
          o_status   = ST_SWEPT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    step    <= step_next;
    k       <= k_next;
    removed <= removed_next;
    if (in_valid && !in_stall) begin
      probe_id  <= track_id;
      probe_rng <= range_sixteenths_km;
    end
    if (load) begin
      status        <= o_status;
      slot          <= SLOT_W'(o_slot);
      entry_count   <= OCNT_W'(count_next);
      removed_count <= (o_status == ST_SWEPT) ? OCNT_W'(removed) : '0;
    end
  end

endmodule

### src/ntt_checker.sv
// ----------------------------------------------------------------------------
// ntt_checker
// Port-level checks for the nearest track table.
// ----------------------------------------------------------------------------
module ntt_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [ntt_pkg::STAT_W-1:0] status,
  input logic [ntt_pkg::SLOT_W-1:0] slot,
  input logic [ntt_pkg::OCNT_W-1:0] entry_count,
  input logic [ntt_pkg::OCNT_W-1:0] removed_count
);
  import ntt_pkg::*;

  // held word stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(slot)
      && $stable(entry_count) && $stable(removed_count))
    else $error("stalled output word changed");

  // one word at a time, so the input closes right after a word is taken
  a_in_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input open right after a word was taken");

  a_report_removed: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_SWEPT |-> removed_count == '0)
    else $error("report word shows removed entries");

  a_zero_slot: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_DROPPED || status == ST_SWEPT) |-> slot == '0)
    else $error("dropped or sweep word shows a slot");

  // a dropped report only happens on a full table
  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_DROPPED |-> entry_count == OCNT_W'(DEPTH))
    else $error("report dropped with room left");

endmodule

bind nearest_track_table ntt_checker u_ntt_checker (.*);
